@@ sv/lru_stack_distance_buckets_unit_defines.svh @@
// Assertion macros for the bucketed LRU stack-distance unit.
// Needs i_clk and i_rst_n in the scope that uses them; no other dependencies.
`ifndef LRU_STACK_DISTANCE_BUCKETS_UNIT_DEFINES_SVH
`define LRU_STACK_DISTANCE_BUCKETS_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LSDB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lsdb assertion failed");

// Next-cycle implication, checked out of reset.
`define LSDB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lsdb assertion failed");

`endif

@@ sv/lsdb_pkg.sv @@
// Shared types and constants for the bucketed LRU stack-distance unit.
// No dependencies; used by the interfaces, the adder unit and the top level.
package lsdb_pkg;

    localparam int CFG_W  = 21;
    localparam int ACT_W  = 32;
    localparam int DIST_W = 21;
    localparam int KIND_W = 2;

    // Operation codes carried in the kind field
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HIT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EVICT = 2'd2;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 21'd4096;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_DEC
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC_RD,
        S_DEC_WR,
        S_HIT_SUM,
        S_HIT_END,
        S_TOP_RD,
        S_TOP_CHK,
        S_AGE_CLR,
        S_AGE_RDB,
        S_AGE_MRG,
        S_AGE_ZERO,
        S_INC_RD,
        S_INC_WR,
        S_DONE
    } t_state;

endpackage

@@ sv/lsdb_if.sv @@
// Valid/ready channel interfaces for the input items and result items.
// Depends on lsdb_pkg for field widths.
interface lsdb_in_if;
    logic                         valid;
    logic                         ready;
    logic [lsdb_pkg::KIND_W-1:0]  kind;
    logic [lsdb_pkg::ACT_W-1:0]   activity;

    modport source (output valid, output kind, output activity, input ready);
    modport sink   (input valid, input kind, input activity, output ready);
endinterface

interface lsdb_out_if;
    logic                         valid;
    logic                         ready;
    logic [lsdb_pkg::ACT_W-1:0]   new_activity;
    logic                         dist_valid;
    logic [lsdb_pkg::DIST_W-1:0]  dist_start;
    logic [lsdb_pkg::DIST_W-1:0]  dist_end;

    modport source (output valid, output new_activity, output dist_valid,
                    output dist_start, output dist_end, input ready);
    modport sink   (input valid, input new_activity, input dist_valid,
                    input dist_start, input dist_end, output ready);
endinterface

@@ sv/lsdb_alu.sv @@
// Shared saturating counter arithmetic: add with clamp at all ones,
// decrement with floor at zero. Depends on lsdb_pkg for the op code type.
module lsdb_alu #(
    parameter int W = 21
) (
    input  lsdb_pkg::t_alu_op i_op,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    output logic [W-1:0]      o_y
);

    logic [W:0] sum;

    assign sum = {1'b0, i_a} + {1'b0, i_b};

    // Pick the operation result
    always_comb begin
        case (i_op)
            lsdb_pkg::ALU_ADD: begin
                o_y = sum[W] ? {W{1'b1}} : sum[W-1:0];
            end
            lsdb_pkg::ALU_DEC: begin
                o_y = (i_a == '0) ? '0 : (i_a - W'(1));
            end
            default: begin
                o_y = i_a;
            end
        endcase
    end

endmodule

@@ sv/lsdb_ring.sv @@
// Ring of bucket counters: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
module lsdb_ring #(
    parameter int DEPTH = 17,
    parameter int AW    = 5,
    parameter int W     = 21
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic         i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0]     r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [W-1:0]     r_rdata;
    logic             r_rvld;

    // Write the counter array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Mark entries once written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // Registered read, hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
            r_rvld  <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

@@ sv/lru_stack_distance_buckets_unit.sv @@
// Bucketed LRU stack-distance estimator. Keeps NUM_BUCKETS age buckets of item
// counts in a ring of NUM_BUCKETS+1 counters plus a 32-bit window base; each
// set, hit or evict returns one result with the item's new tag and, for hits,
// the stack-distance interval [dist_start, dist_end). The block takes one item
// at a time through a single counter memory port and one shared saturating
// adder. A hit reads one bucket per cycle from the top bucket down to the
// item's bucket, rel buckets above the bottom. A hit or evict with a zero tag,
// or the unused kind 3, goes straight to the result. A set or hit whose top
// bucket reaches the limit first ages the window: clear, read, merge, zero.
// A new input is taken while the previous result waits at the output.
// Depends on lsdb_pkg, lsdb_if, lsdb_alu, lsdb_ring and the defines header.
`include "lru_stack_distance_buckets_unit_defines.svh"

module lru_stack_distance_buckets_unit #(
    parameter int NUM_BUCKETS = 16,
    parameter int COUNT_BITS  = 21
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lsdb_pkg::CFG_W-1:0]    i_cfg_wdata,
    lsdb_in_if.sink                       i_in,
    lsdb_out_if.source                    o_out
);

    localparam int RING   = NUM_BUCKETS + 1;
    localparam int SLOT_W = $clog2(RING);
    localparam int IDX_W  = $clog2(NUM_BUCKETS);
    localparam int CMP_W  = COUNT_BITS + lsdb_pkg::CFG_W;
    localparam int WIDE_W = COUNT_BITS + lsdb_pkg::DIST_W;
    localparam int ACT_W  = lsdb_pkg::ACT_W;
    localparam int DIST_W = lsdb_pkg::DIST_W;

    localparam logic [ACT_W:0]    BASE_MAX = {1'b1, {ACT_W{1'b0}}} - (ACT_W+1)'(NUM_BUCKETS);
    localparam logic [SLOT_W-1:0] OFF_ZERO = '0;
    localparam logic [SLOT_W-1:0] OFF_ONE  = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] OFF_TOP  = SLOT_W'(NUM_BUCKETS - 1);
    localparam logic [SLOT_W-1:0] OFF_NEW  = SLOT_W'(NUM_BUCKETS);
    localparam logic [IDX_W-1:0]  IDX_TOP  = IDX_W'(NUM_BUCKETS - 1);

    // Slot of (base + k) in the ring, k below RING
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                   input logic [SLOT_W-1:0] k);
        logic [SLOT_W:0] sum;
        sum = {1'b0, s} + {1'b0, k};
        if (sum >= (SLOT_W+1)'(RING)) begin
            sum = sum - (SLOT_W+1)'(RING);
        end
        return sum[SLOT_W-1:0];
    endfunction

    lsdb_pkg::t_state r_state, n_state;

    logic [lsdb_pkg::CFG_W-1:0]  r_limit;
    logic [ACT_W-1:0]            r_base, n_base;
    logic [SLOT_W-1:0]           r_base_slot, n_base_slot;
    logic [lsdb_pkg::KIND_W-1:0] r_kind;
    logic [IDX_W-1:0]            r_rel, n_rel;
    logic [IDX_W-1:0]            r_idx, n_idx;
    logic                        r_pend, n_pend;
    logic [COUNT_BITS-1:0]       r_start, n_start;
    logic [COUNT_BITS-1:0]       r_end, n_end;
    logic [COUNT_BITS-1:0]       r_tmp, n_tmp;
    logic [ACT_W-1:0]            r_new_act, n_new_act;
    logic                        r_dvalid, n_dvalid;

    logic                        r_o_valid;
    logic [ACT_W-1:0]            r_o_new_act;
    logic                        r_o_dvalid;
    logic [DIST_W-1:0]           r_o_start;
    logic [DIST_W-1:0]           r_o_end;

    logic                        in_xfer;
    logic                        act_zero;
    logic                        act_below;
    logic [ACT_W-1:0]            act_diff;
    logic [IDX_W-1:0]            rel_in;
    logic                        age_go;
    logic                        out_load;
    logic [WIDE_W-1:0]           start_wide;
    logic [WIDE_W-1:0]           end_wide;

    logic                        rd_en;
    logic [SLOT_W-1:0]           rd_off;
    logic [COUNT_BITS-1:0]       rd_data;
    logic                        wr_en;
    logic [SLOT_W-1:0]           wr_off;
    logic [COUNT_BITS-1:0]       wr_data;
    lsdb_pkg::t_alu_op           alu_op;
    logic [COUNT_BITS-1:0]       alu_a;
    logic [COUNT_BITS-1:0]       alu_b;
    logic [COUNT_BITS-1:0]       alu_y;

    lsdb_ring #(
        .DEPTH (RING),
        .AW    (SLOT_W),
        .W     (COUNT_BITS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (wr_en),
        .i_waddr (slot_add(r_base_slot, wr_off)),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (slot_add(r_base_slot, rd_off)),
        .o_rdata (rd_data)
    );

    lsdb_alu #(
        .W (COUNT_BITS)
    ) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    // Input handshake and tag clamp into a bucket offset
    assign i_in.ready = (r_state == lsdb_pkg::S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign act_zero   = (i_in.activity == '0);
    assign act_below  = (i_in.activity < r_base);
    assign act_diff   = i_in.activity - r_base;
    assign rel_in     = act_below ? '0 :
                        (act_diff > ACT_W'(NUM_BUCKETS - 1)) ? IDX_TOP : act_diff[IDX_W-1:0];

    // Ageing needed and allowed
    assign age_go = (CMP_W'(rd_data) >= CMP_W'(r_limit)) && ({1'b0, r_base} < BASE_MAX);

    assign out_load = (r_state == lsdb_pkg::S_DONE) && (!r_o_valid || o_out.ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsdb_pkg::S_IDLE: begin
                if (in_xfer) begin
                    case (i_in.kind)
                        lsdb_pkg::KIND_SET:   n_state = act_zero ? lsdb_pkg::S_TOP_RD
                                                                 : lsdb_pkg::S_DEC_RD;
                        lsdb_pkg::KIND_HIT:   n_state = act_zero ? lsdb_pkg::S_DONE
                                                                 : lsdb_pkg::S_HIT_SUM;
                        lsdb_pkg::KIND_EVICT: n_state = act_zero ? lsdb_pkg::S_DONE
                                                                 : lsdb_pkg::S_DEC_RD;
                        default:              n_state = lsdb_pkg::S_DONE;
                    endcase
                end
            end
            lsdb_pkg::S_DEC_RD:   n_state = lsdb_pkg::S_DEC_WR;
            lsdb_pkg::S_DEC_WR: begin
                n_state = (r_kind == lsdb_pkg::KIND_EVICT) ? lsdb_pkg::S_DONE
                                                           : lsdb_pkg::S_TOP_RD;
            end
            lsdb_pkg::S_HIT_SUM: begin
                if (r_idx == r_rel) begin
                    n_state = lsdb_pkg::S_HIT_END;
                end
            end
            lsdb_pkg::S_HIT_END:  n_state = lsdb_pkg::S_DEC_WR;
            lsdb_pkg::S_TOP_RD:   n_state = lsdb_pkg::S_TOP_CHK;
            lsdb_pkg::S_TOP_CHK:  n_state = age_go ? lsdb_pkg::S_AGE_CLR : lsdb_pkg::S_INC_WR;
            lsdb_pkg::S_AGE_CLR:  n_state = lsdb_pkg::S_AGE_RDB;
            lsdb_pkg::S_AGE_RDB:  n_state = lsdb_pkg::S_AGE_MRG;
            lsdb_pkg::S_AGE_MRG:  n_state = lsdb_pkg::S_AGE_ZERO;
            lsdb_pkg::S_AGE_ZERO: n_state = lsdb_pkg::S_INC_RD;
            lsdb_pkg::S_INC_RD:   n_state = lsdb_pkg::S_INC_WR;
            lsdb_pkg::S_INC_WR:   n_state = lsdb_pkg::S_DONE;
            lsdb_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = lsdb_pkg::S_IDLE;
                end
            end
            default:              n_state = lsdb_pkg::S_IDLE;
        endcase
    end

    // Datapath controls: memory port, shared adder, working registers
    always_comb begin
        n_base      = r_base;
        n_base_slot = r_base_slot;
        n_rel       = r_rel;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_start     = r_start;
        n_end       = r_end;
        n_tmp       = r_tmp;
        n_new_act   = r_new_act;
        n_dvalid    = r_dvalid;
        rd_en       = 1'b0;
        rd_off      = OFF_ZERO;
        wr_en       = 1'b0;
        wr_off      = OFF_ZERO;
        wr_data     = alu_y;
        alu_op      = lsdb_pkg::ALU_ADD;
        alu_a       = rd_data;
        alu_b       = '0;
        case (r_state)
            lsdb_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_rel     = rel_in;
                    n_idx     = IDX_TOP;
                    n_pend    = 1'b0;
                    n_start   = '0;
                    n_end     = '0;
                    n_dvalid  = 1'b0;
                    n_new_act = '0;
                end
            end
            lsdb_pkg::S_DEC_RD: begin
                rd_en  = 1'b1;
                rd_off = SLOT_W'(r_rel);
            end
            lsdb_pkg::S_DEC_WR: begin
                alu_op = lsdb_pkg::ALU_DEC;
                wr_en  = 1'b1;
                wr_off = SLOT_W'(r_rel);
            end
            lsdb_pkg::S_HIT_SUM: begin
                // read one bucket, add the one read last cycle
                rd_en  = 1'b1;
                rd_off = SLOT_W'(r_idx);
                n_pend = 1'b1;
                if (r_pend) begin
                    alu_a   = r_start;
                    alu_b   = rd_data;
                    n_start = alu_y;
                end
                if (r_idx != r_rel) begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            lsdb_pkg::S_HIT_END: begin
                alu_a    = r_start;
                alu_b    = rd_data;
                n_end    = alu_y;
                n_dvalid = 1'b1;
            end
            lsdb_pkg::S_TOP_RD: begin
                rd_en  = 1'b1;
                rd_off = OFF_TOP;
            end
            lsdb_pkg::S_TOP_CHK: begin
                rd_en = 1'b0;
            end
            lsdb_pkg::S_AGE_CLR: begin
                // clear the new top, start reading the old bottom
                wr_en   = 1'b1;
                wr_off  = OFF_NEW;
                wr_data = '0;
                rd_en   = 1'b1;
                rd_off  = OFF_ZERO;
            end
            lsdb_pkg::S_AGE_RDB: begin
                rd_en  = 1'b1;
                rd_off = OFF_ONE;
                n_tmp  = rd_data;
            end
            lsdb_pkg::S_AGE_MRG: begin
                alu_b  = r_tmp;
                wr_en  = 1'b1;
                wr_off = OFF_ONE;
            end
            lsdb_pkg::S_AGE_ZERO: begin
                // drop the old bottom and advance the window
                wr_en       = 1'b1;
                wr_off      = OFF_ZERO;
                wr_data     = '0;
                n_base      = r_base + ACT_W'(1);
                n_base_slot = slot_add(r_base_slot, OFF_ONE);
            end
            lsdb_pkg::S_INC_RD: begin
                rd_en  = 1'b1;
                rd_off = OFF_TOP;
            end
            lsdb_pkg::S_INC_WR: begin
                alu_b     = COUNT_BITS'(1);
                wr_en     = 1'b1;
                wr_off    = OFF_TOP;
                n_new_act = r_base + ACT_W'(NUM_BUCKETS - 1);
            end
            lsdb_pkg::S_DONE: begin
                rd_en = 1'b0;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsdb_pkg::S_IDLE;
            r_limit     <= lsdb_pkg::LIMIT_RESET;
            r_base      <= ACT_W'(1);
            r_base_slot <= SLOT_W'(1);
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_base_slot <= n_base_slot;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind <= i_in.kind;
        end
        r_rel     <= n_rel;
        r_idx     <= n_idx;
        r_pend    <= n_pend;
        r_start   <= n_start;
        r_end     <= n_end;
        r_tmp     <= n_tmp;
        r_new_act <= n_new_act;
        r_dvalid  <= n_dvalid;
    end

    // Fit counts to the distance field width
    assign start_wide = WIDE_W'(r_start);
    assign end_wide   = WIDE_W'(r_end);

    // Output register, holds the result until transferred
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_new_act <= r_new_act;
            r_o_dvalid  <= r_dvalid;
            r_o_start   <= start_wide[DIST_W-1:0];
            r_o_end     <= end_wide[DIST_W-1:0];
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.new_activity = r_o_new_act;
    assign o_out.dist_valid   = r_o_dvalid;
    assign o_out.dist_start   = r_o_start;
    assign o_out.dist_end     = r_o_end;

    `LSDB_ASSERT_NEXT(a_accept_leaves_idle, in_xfer, r_state != lsdb_pkg::S_IDLE)
    `LSDB_ASSERT_NEXT(a_base_steps_by_one, 1'b1, (r_base - $past(r_base)) <= ACT_W'(1))
    `LSDB_ASSERT_NOW(a_base_slot_in_ring, 1'b1, r_base_slot <= OFF_NEW)

endmodule
